@@ src/ppd_pkg.sv @@
`timescale 1ns / 1ps
package ppd_pkg;

  localparam int unsigned NumPrimes = 18;
  localparam int unsigned MaskW = 18;
  localparam int unsigned ExpW = 7;
  localparam int unsigned PrimeIdxW = 5;
  localparam int unsigned RootBitW = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_BIT,
    ST_POW,
    ST_DECIDE,
    ST_FINAL,
    ST_FPOW,
    ST_APPLY,
    ST_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // take input value
    logic mask_load;   // latch residue mask
    logic prime_clr;   // prime index to zero
    logic prime_next;  // advance prime index
    logic root_start;  // r = 0, bit = 31
    logic cand_start;  // acc = 1, step = 0, candidate = r | bit
    logic fin_start;   // acc = 1, step = 0, candidate = r
    logic pow_step;    // one half of a multiply step
    logic bit_commit;  // keep candidate if it fit, go to next bit
    logic apply;       // n = r, power *= p
    logic out_load;    // capture result
  } ppd_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic below_two;   // n < 2
    logic mask_zero;   // residue mask empty
    logic prime_end;   // prime index past last
    logic prime_set;   // current prime allowed by mask
    logic pow_done;    // multiply steps finished
    logic fits;        // candidate^k <= n so far
    logic last_bit;    // bit index at zero
    logic exact;       // final check: r^p == n and r >= 2
  } ppd_stat_t;

  function automatic logic [5:0] prime_at(input logic [PrimeIdxW-1:0] idx);
    logic [5:0] p;
    unique case (idx)
      5'd0: p = 6'd2;
      5'd1: p = 6'd3;
      5'd2: p = 6'd5;
      5'd3: p = 6'd7;
      5'd4: p = 6'd11;
      5'd5: p = 6'd13;
      5'd6: p = 6'd17;
      5'd7: p = 6'd19;
      5'd8: p = 6'd23;
      5'd9: p = 6'd29;
      5'd10: p = 6'd31;
      5'd11: p = 6'd37;
      5'd12: p = 6'd41;
      5'd13: p = 6'd43;
      5'd14: p = 6'd47;
      5'd15: p = 6'd53;
      5'd16: p = 6'd59;
      5'd17: p = 6'd61;
      default: p = 6'd2;
    endcase
    return p;
  endfunction

  function automatic logic [MaskW-1:0] mask32(input logic [4:0] r);
    logic [MaskW-1:0] m;
    unique case (r)
      5'd0, 5'd1, 5'd9, 5'd17, 5'd25: m = 18'd262143;
      5'd4, 5'd16: m = 18'd1;
      5'd8, 5'd24: m = 18'd2;
      5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd15, 5'd19, 5'd21, 5'd23,
      5'd27, 5'd29, 5'd31: m = 18'd262142;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [MaskW-1:0] mask27(input logic [4:0] r);
    logic [MaskW-1:0] m;
    unique case (r)
      5'd0, 5'd1, 5'd10, 5'd19: m = 18'd262143;
      5'd2, 5'd5, 5'd11, 5'd14, 5'd20, 5'd23: m = 18'd262140;
      5'd4, 5'd7, 5'd13, 5'd16, 5'd22, 5'd25: m = 18'd262141;
      5'd8, 5'd17, 5'd26: m = 18'd262142;
      5'd9: m = 18'd1;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ src/perfect_power_detector.sv @@
`timescale 1ns / 1ps
// Perfect power detector. Takes one unsigned number per item and returns
// base_root and exponent with base_root**exponent == value (exponent 1 when
// value is not a perfect power, below two, or ruled out by the mod-32 and
// mod-27 residue masks). One item is worked at a time. Rejected inputs finish
// straight after the input check; otherwise the work grows with each allowed
// prime p: each root search walks 32 bits, and every multiply step runs as two
// halves on one shared 32x32 multiplier. Overflow exits cut most bits short.
// The result is held in an output register until taken.
module perfect_power_detector #(
  parameter int unsigned WORD_BITS   = 64,
  parameter int unsigned PRIME_COUNT = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        value_valid_i,
  output logic        value_ready_o,
  input  logic [63:0] value_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [63:0] base_root_o,
  output logic [6:0]  exponent_o
);

  ppd_pkg::ppd_cmd_t  cmd;
  ppd_pkg::ppd_stat_t stat;

  ppd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (value_valid_i),
    .in_ready_o  (value_ready_o),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ppd_datapath #(
    .WORD_BITS   (WORD_BITS),
    .PRIME_COUNT (PRIME_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .base_root_o (base_root_o),
    .exponent_o  (exponent_o)
  );

endmodule

@@ src/ppd_ctrl.sv @@
`timescale 1ns / 1ps
module ppd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ppd_pkg::ppd_stat_t  stat_i,
  output ppd_pkg::ppd_cmd_t   cmd_o
);

  ppd_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ppd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppd_pkg::ST_IDLE:   if (in_valid_i) state_d = ppd_pkg::ST_CHECK;
      ppd_pkg::ST_CHECK: begin
        if (stat_i.below_two || stat_i.mask_zero) state_d = ppd_pkg::ST_DONE;
        else state_d = ppd_pkg::ST_SCAN;
      end
      ppd_pkg::ST_SCAN: begin
        if (stat_i.prime_end) state_d = ppd_pkg::ST_DONE;
        else if (stat_i.prime_set) state_d = ppd_pkg::ST_BIT;
      end
      ppd_pkg::ST_BIT:    state_d = ppd_pkg::ST_POW;
      ppd_pkg::ST_POW:    if (stat_i.pow_done || !stat_i.fits) state_d = ppd_pkg::ST_DECIDE;
      ppd_pkg::ST_DECIDE: state_d = stat_i.last_bit ? ppd_pkg::ST_FINAL : ppd_pkg::ST_BIT;
      ppd_pkg::ST_FINAL:  state_d = ppd_pkg::ST_FPOW;
      ppd_pkg::ST_FPOW:   if (stat_i.pow_done || !stat_i.fits) state_d = ppd_pkg::ST_APPLY;
      ppd_pkg::ST_APPLY:  state_d = ppd_pkg::ST_SCAN;
      ppd_pkg::ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ppd_pkg::ST_IDLE;
      default:            state_d = ppd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ppd_pkg::ST_IDLE:   cmd_o.load = in_valid_i;
      ppd_pkg::ST_CHECK: begin
        cmd_o.mask_load = 1'b1;
        cmd_o.prime_clr = 1'b1;
      end
      ppd_pkg::ST_SCAN: begin
        if (!stat_i.prime_end && stat_i.prime_set) cmd_o.root_start = 1'b1;
        else if (!stat_i.prime_end) cmd_o.prime_next = 1'b1;
      end
      ppd_pkg::ST_BIT:    cmd_o.cand_start = 1'b1;
      ppd_pkg::ST_POW:    cmd_o.pow_step = !(stat_i.pow_done || !stat_i.fits);
      ppd_pkg::ST_DECIDE: cmd_o.bit_commit = 1'b1;
      ppd_pkg::ST_FINAL:  cmd_o.fin_start = 1'b1;
      ppd_pkg::ST_FPOW:   cmd_o.pow_step = !(stat_i.pow_done || !stat_i.fits);
      ppd_pkg::ST_APPLY: begin
        // exact root: replace and retry same prime; else move on
        if (stat_i.exact) cmd_o.apply = 1'b1;
        else cmd_o.prime_next = 1'b1;
      end
      ppd_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ppd_pkg::ST_CHECK)
    else $error("accept did not start work");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ppd_pkg::ST_DONE)
    else $error("result without done state");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.apply, cmd_o.prime_next, cmd_o.root_start}))
    else $error("conflicting commands");

endmodule

@@ src/ppd_datapath.sv @@
`timescale 1ns / 1ps
module ppd_datapath #(
  parameter int unsigned WORD_BITS   = 64,
  parameter int unsigned PRIME_COUNT = 18
) (
  input  logic               clk_i,
  input  logic [63:0]        value_i,
  input  ppd_pkg::ppd_cmd_t  cmd_i,
  output ppd_pkg::ppd_stat_t stat_o,
  output logic [63:0]        base_root_o,
  output logic [6:0]         exponent_o
);

  localparam logic [ppd_pkg::PrimeIdxW-1:0] LastIdx =
    ppd_pkg::PrimeIdxW'(PRIME_COUNT);

  logic [WORD_BITS-1:0] n_q, r_q, cand_q, acc_q;
  logic [ppd_pkg::MaskW-1:0] mask_q;
  logic [ppd_pkg::PrimeIdxW-1:0] pidx_q;
  logic [ppd_pkg::RootBitW-1:0] bit_q;
  logic [5:0] step_q;
  logic fits_q;
  logic phase_q;
  logic [63:0] lo_q;
  logic [ppd_pkg::ExpW-1:0] power_q;
  logic [63:0] base_q;
  logic [6:0] exp_q;

  logic [5:0] prime;
  logic [63:0] acc_w, cand_w, n_w;
  logic [31:0] mul_a;
  logic [63:0] mul;
  logic [95:0] full;
  logic [19:0] fold;
  logic [40:0] qprod;
  logic [15:0] quot;
  logic [4:0] mod27;
  logic [WORD_BITS-1:0] bitv;

  assign prime = ppd_pkg::prime_at(pidx_q);
  assign bitv  = WORD_BITS'(1) << bit_q;

  // One 32x32 multiplier, used twice per step: low half of acc, then high.
  // Candidates stay below 2**32, so the candidate needs only its low half.
  assign acc_w  = 64'(acc_q);
  assign cand_w = 64'(cand_q);
  assign n_w    = 64'(n_q);
  assign mul_a  = phase_q ? acc_w[63:32] : acc_w[31:0];
  assign mul    = mul_a * cand_w[31:0];
  assign full   = {mul, 32'h0} + {32'h0, lo_q};

  // n mod 27: 2**18 == 1 (mod 27) folds the word into a 20-bit sum, then
  // a multiply by ceil(2**25 / 27) gives the exact quotient of that sum
  assign fold  = 20'(n_w[17:0]) + 20'(n_w[35:18]) + 20'(n_w[53:36])
               + 20'(n_w[63:54]);
  assign qprod = 41'(fold) * 41'(21'd1242757);
  assign quot  = qprod[40:25];
  assign mod27 = 5'(fold - 20'(quot) * 20'd27);

  always_comb begin
    stat_o.below_two = (n_q < WORD_BITS'(2));
    stat_o.mask_zero = ((ppd_pkg::mask32(n_q[4:0]) & ppd_pkg::mask27(mod27)) == '0);
    stat_o.prime_end = (pidx_q >= LastIdx);
    stat_o.prime_set = mask_q[pidx_q];
    stat_o.pow_done  = (step_q == prime);
    stat_o.fits      = fits_q;
    stat_o.last_bit  = (bit_q == '0);
    stat_o.exact     = fits_q && (acc_q == n_q) && (r_q >= WORD_BITS'(2));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) n_q <= value_i[WORD_BITS-1:0];
    if (cmd_i.load) power_q <= ppd_pkg::ExpW'(1);
    if (cmd_i.mask_load)
      mask_q <= ppd_pkg::mask32(n_q[4:0]) & ppd_pkg::mask27(mod27);
    if (cmd_i.prime_clr) pidx_q <= '0;
    if (cmd_i.prime_next) pidx_q <= pidx_q + 1'b1;
    if (cmd_i.root_start) begin
      r_q   <= '0;
      bit_q <= ppd_pkg::RootBitW'(31);
    end
    if (cmd_i.cand_start || cmd_i.fin_start) begin
      acc_q   <= WORD_BITS'(1);
      step_q  <= '0;
      fits_q  <= 1'b1;
      phase_q <= 1'b0;
      // bits past the word shift out of bitv and leave r unchanged
      cand_q  <= cmd_i.cand_start ? (r_q | bitv) : r_q;
    end
    if (cmd_i.pow_step) begin
      phase_q <= ~phase_q;
      if (!phase_q) begin
        lo_q <= mul;
      end else begin
        step_q <= step_q + 1'b1;
        if ((full[95:64] != '0) || (full[63:0] > n_w) || (cand_q == '0))
          fits_q <= 1'b0;
        else acc_q <= WORD_BITS'(full[63:0]);
      end
    end
    if (cmd_i.bit_commit) begin
      if (fits_q && cand_q != '0) r_q <= cand_q;
      bit_q <= bit_q - 1'b1;
    end
    if (cmd_i.apply) begin
      n_q     <= r_q;
      power_q <= ppd_pkg::ExpW'(power_q * prime);
    end
    if (cmd_i.out_load) begin
      base_q <= 64'(n_q);
      exp_q  <= power_q;
    end
  end

  assign base_root_o = base_q;
  assign exponent_o  = exp_q;

endmodule

@@ dv/perfect_power_detector_tb.sv @@
`timescale 1ns / 1ps
module perfect_power_detector_tb;

  // Known answer: root and exponent of one item.
  typedef struct {
    logic [63:0] root;
    logic [6:0]  expo;
  } power_t;

  // Directed row; typed answers only where obvious, else predictor.
  typedef struct {
    logic [63:0] value;
    bit          typed;
    logic [63:0] root;
    logic [6:0]  expo;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        value_valid_i;
  logic        value_ready_o;
  logic [63:0] value_i;
  logic        result_valid_o;
  logic        result_ready_i;
  logic [63:0] base_root_o;
  logic [6:0]  exponent_o;

  power_t      pending_q[$];
  int unsigned err_cnt;
  bit          stim_done;

  perfect_power_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_ready_o (value_ready_o),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .base_root_o   (base_root_o),
    .exponent_o    (exponent_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: 140 items plus stalls fit well inside this timeout.
  initial begin
    #1000ms;
    $display("FAIL");
    $finish;
  end

  // c**k <= n, with early exit before overflow; exact when c**k == n.
  function automatic bit fits_pow(input logic [63:0] c, input int k,
                                  input logic [63:0] n, output bit exact);
    logic [63:0] acc;
    acc = 64'd1;
    exact = 1'b0;
    for (int j = 0; j < k; j++) begin
      if (acc > n / c) return 1'b0;
      acc = acc * c;
    end
    exact = (acc == n);
    return 1'b1;
  endfunction

  // Largest r < 2**32 with r**k <= n, searched bit by bit.
  function automatic logic [63:0] floor_root(input logic [63:0] n, input int k,
                                             output bit exact);
    logic [63:0] r;
    logic [63:0] c;
    bit          e;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (fits_pow(c, k, n, e)) r = c;
    end
    exact = 1'b0;
    if (r != 0) void'(fits_pow(r, k, n, exact));
    return r;
  endfunction

  function automatic power_t predict_power(input logic [63:0] value);
    power_t                    res;
    logic [ppd_pkg::MaskW-1:0] allowed;
    logic [63:0]               r;
    bit                        exact;
    int                        p;
    res.root = value;
    res.expo = 7'd1;
    if (value < 2) return res;
    allowed = ppd_pkg::mask32(value[4:0]) & ppd_pkg::mask27(5'(value % 27));
    if (allowed == 0) return res;
    for (int i = 0; i < ppd_pkg::NumPrimes; i++) begin
      if (allowed[i]) begin
        p = ppd_pkg::prime_at(5'(i));
        forever begin
          r = floor_root(res.root, p, exact);
          if (!exact || r < 2) break;
          res.root = r;
          res.expo = 7'(res.expo * p);
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Hand one item over; valid stays up across back-to-back items.
  task automatic send_item(input logic [63:0] v, input power_t want);
    value_i       <= v;
    value_valid_i <= 1'b1;
    do @(posedge clk_i); while (!value_ready_o);
    pending_q.push_back(want);
  endtask

  // Sender idles between bursts of random length.
  int burst_left;
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 5);
      if ($urandom_range(0, 2) != 0) begin
        value_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // b**e, or 0 when it overflows 64 bits.
  function automatic logic [63:0] raise(input logic [63:0] b, input int e);
    logic [63:0] acc;
    acc = 64'd1;
    for (int j = 0; j < e; j++) begin
      if (acc > 64'hFFFF_FFFF_FFFF_FFFF / b) return '0;
      acc = acc * b;
    end
    return acc;
  endfunction

  // Mostly true powers with random base and exponent, the rest noise.
  function automatic logic [63:0] pick_value();
    logic [63:0] b;
    logic [63:0] v;
    int          e;
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2:    return 64'(1) << $urandom_range(0, 63);
      3:    return 64'($urandom_range(0, 40));
      default: begin
        e = $urandom_range(2, 40);
        b = {$urandom, $urandom} >> $urandom_range(64 - 64 / e, 63);
        if (b < 2) b = 64'($urandom_range(2, 7));
        v = raise(b, e);
        if (v == 0) v = raise(b, 2);
        if (v == 0) v = b;
        // nudge off a true power now and then
        if ($urandom_range(0, 7) == 0) v = v + 64'd1;
        return v;
      end
    endcase
  endfunction

  row_t rows[] = '{
    '{64'd0,  1'b1, 64'd0, 7'd1},               // below two
    '{64'd1,  1'b1, 64'd1, 7'd1},               // below two
    '{64'd2,  1'b1, 64'd2, 7'd1},               // residue reject
    '{64'd6,  1'b1, 64'd6, 7'd1},               // residue reject
    '{64'd4,  1'b1, 64'd2, 7'd2},
    '{64'd8,  1'b1, 64'd2, 7'd3},
    '{64'd9,  1'b1, 64'd3, 7'd2},
    '{64'd27, 1'b1, 64'd3, 7'd3},
    '{64'd64, 1'b1, 64'd2, 7'd6},
    '{64'd3,  1'b0, '0, '0},
    '{64'd17, 1'b0, '0, '0},
    '{64'h4000_0000_0000_0000, 1'b1, 64'd2, 7'd62},
    '{64'h8000_0000_0000_0000, 1'b1, 64'd2, 7'd63},  // 2**63, exponent 3*3*7
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, '0},        // all ones
    '{64'hFFFF_FFFE_0000_0001, 1'b1, 64'hFFFF_FFFF, 7'd2}, // largest square
    '{64'hFFFF_FFFF_0000_0000, 1'b0, '0, '0},
    '{64'd12157665459056928801, 1'b1, 64'd3, 7'd40}, // 3**40
    '{64'd3909821048582988049, 1'b1, 64'd7, 7'd22},  // 7**22
    '{64'd1220703125, 1'b1, 64'd5, 7'd13},           // 5**13
    '{64'd2251799813685248, 1'b1, 64'd2, 7'd51},     // 2**51
    '{64'd1000000000000000000, 1'b0, '0, '0},
    '{64'd999999999999999999, 1'b0, '0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, '0}
  };

  // Stimulus.
  initial begin
    power_t      want;
    logic [63:0] v;
    rst_ni        = 1'b0;
    value_valid_i = 1'b0;
    value_i       = '0;
    err_cnt       = 0;
    stim_done     = 1'b0;
    burst_left    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        want.root = rows[i].root;
        want.expo = rows[i].expo;
      end else begin
        want = predict_power(rows[i].value);
      end
      send_item(rows[i].value, want);
      maybe_gap();
    end

    for (int n = 0; n < 116; n++) begin
      // drain once mid-run so the block restarts from idle
      if (n == 58) begin
        value_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      v = pick_value();
      send_item(v, predict_power(v));
      maybe_gap();
    end
    value_valid_i <= 1'b0;
    stim_done     <= 1'b1;
  end

  // Receiver: rotating 16-bit stall pattern, refreshed with a new random one,
  // sometimes all-ready stretches.
  logic [15:0] ready_pat;
  int unsigned pat_age;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_pat      <= 16'hFFFF;
      pat_age        <= 0;
      result_ready_i <= 1'b0;
    end else begin
      pat_age        <= pat_age + 1;
      result_ready_i <= ready_pat[0];
      if (pat_age % 64 == 63) begin
        ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  // Result check against the oldest pending item.
  always @(posedge clk_i) begin
    power_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result root", base_root_o, '0);
      end else begin
        want = pending_q.pop_front();
        if (base_root_o !== want.root)
          report_mismatch("base_root", base_root_o, want.root);
        if (exponent_o !== want.expo)
          report_mismatch("exponent", 64'(exponent_o), 64'(want.expo));
      end
    end
  end

  // End of run: drain, then a short settle for stray results.
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ppd_pkg.sv
src/ppd_ctrl.sv
src/ppd_datapath.sv
src/perfect_power_detector.sv
dv/perfect_power_detector_tb.sv
